/* rtl/core/backslash_escape_decoder_core_assert.svh */
// assertion macros for the decoder core rtl
`ifndef BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bed assertion failed");

// next-cycle implication, checked out of reset
`define BED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bed assertion failed");

`endif

/* rtl/core/bed_pkg.sv */
package bed_pkg;

    // parser modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_HASH = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;
    localparam logic [2:0] MODE_DEC  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BS_END    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_REF_END   = 3'd3;
    localparam logic [2:0] ST_BAD_START = 3'd4;
    localparam logic [2:0] ST_NOT_UNI   = 3'd5;

    // characters
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    localparam logic [15:0] REF_LIMIT = 16'hfffe;
    localparam logic [15:0] ACC_MAX   = 16'hffff;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [15:0] char_code;
        logic [2:0]  status;
        logic        run_last;
        logic        text_done;
    } out_t;

    // one queue slot: the results of one byte
    typedef struct packed {
        out_t first;
        out_t second;
        logic two;
    } entry_t;

    typedef struct packed {
        logic mode_idle;
        logic accum_zero;
    } front_stat_t;

endpackage

/* rtl/core/bed_front.sv */
module bed_front
    import bed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    input  logic        q_ready,
    output logic        push,
    output entry_t      push_data,
    output front_stat_t stat
);

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] accum_reg, accum_next;
    logic [7:0]  b;
    logic        last, accept;
    logic        dec_ok, hex_ok;
    logic [3:0]  hex_val;
    logic [19:0] sum16, sum10;
    logic [15:0] acc16, acc10;
    out_t        r0, r1;
    logic        have0, have1;

    function automatic out_t finish(input logic [15:0] v);
        out_t r;
        r = '0;
        if (v == 16'd0 || v >= REF_LIMIT)
            r.status = ST_NOT_UNI;
        else
        begin
            r.char_code = v;
            r.status    = ST_OK;
        end
        return r;
    endfunction

    assign b        = in_data.in_byte;
    assign last     = in_data.end_of_text;
    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    assign dec_ok  = b inside {[CH_0:CH_9]};
    assign hex_ok  = dec_ok || (b inside {[CH_LA:CH_LF]}) || (b inside {[CH_UA:CH_UF]});
    assign hex_val = dec_ok ? b[3:0] : 4'(b[3:0] + 4'd9);

    // saturating multiply-accumulate for both bases
    assign sum16 = {accum_reg, 4'b0000} + {16'd0, hex_val};
    assign sum10 = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0} + {16'd0, b[3:0]};
    assign acc16 = (|sum16[19:16]) ? ACC_MAX : sum16[15:0];
    assign acc10 = (|sum10[19:16]) ? ACC_MAX : sum10[15:0];

    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        r0    = '0;
        r1    = '0;
        have0 = 1'b0;
        have1 = 1'b0;
        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_IDLE;
                have0     = 1'b1;
                r0.status = ST_OK;
                case (b)
                    CH_T:      r0.char_code = 16'd9;
                    CH_N:      r0.char_code = 16'd10;
                    CH_R:      r0.char_code = 16'd13;
                    CH_F:      r0.char_code = 16'd12;
                    CH_B:      r0.char_code = 16'd8;
                    CH_BSLASH: r0.char_code = 16'd92;
                    CH_QUOTE:  r0.char_code = 16'd34;
                    CH_NL:     r0.char_code = 16'd10;
                    CH_HASH:
                    begin
                        if (last)
                            r0.status = ST_REF_END;
                        else
                        begin
                            have0     = 1'b0;
                            mode_next = MODE_HASH;
                        end
                    end
                    default:   r0.status = ST_UNKNOWN;
                endcase
            end
            MODE_HASH:
            begin
                accum_next = 16'd0;
                if (b == CH_X)
                begin
                    mode_next = MODE_HEX;
                    have0     = last;
                    r0        = finish(16'd0);
                end
                else if (dec_ok)
                begin
                    accum_next = {12'd0, b[3:0]};
                    mode_next  = MODE_DEC;
                    have0      = last;
                    r0         = finish({12'd0, b[3:0]});
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    have0     = 1'b1;
                    r0.status = ST_BAD_START;
                end
            end
            MODE_HEX, MODE_DEC:
            begin
                if ((mode_reg == MODE_HEX) ? hex_ok : dec_ok)
                begin
                    accum_next = (mode_reg == MODE_HEX) ? acc16 : acc10;
                    have0      = last;
                    r0         = finish(accum_next);
                end
                else
                begin
                    // reference ends here
                    have0      = 1'b1;
                    r0         = finish(accum_reg);
                    mode_next  = MODE_IDLE;
                    accum_next = 16'd0;
                    if (b != CH_SEMI)
                    begin
                        // terminator is parsed again as a plain byte
                        if (b == CH_BSLASH)
                        begin
                            if (last)
                            begin
                                have1     = 1'b1;
                                r1.status = ST_BS_END;
                            end
                            else
                                mode_next = MODE_ESC;
                        end
                        else
                        begin
                            have1        = 1'b1;
                            r1.char_code = {8'd0, b};
                        end
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (b == CH_BSLASH)
                begin
                    if (last)
                    begin
                        have0     = 1'b1;
                        r0.status = ST_BS_END;
                    end
                    else
                        mode_next = MODE_ESC;
                end
                else
                begin
                    have0        = 1'b1;
                    r0.char_code = {8'd0, b};
                end
            end
        endcase
        if (last)
        begin
            mode_next  = MODE_IDLE;
            accum_next = 16'd0;
        end
        r0.text_done = last;
        r1.text_done = last;
        r0.run_last  = !have1;
        r1.run_last  = 1'b1;
    end

    assign push           = accept && have0;
    assign push_data.first  = r0;
    assign push_data.second = r1;
    assign push_data.two    = have1;

    assign stat.mode_idle  = (mode_reg == MODE_IDLE);
    assign stat.accum_zero = (accum_reg == 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            accum_reg <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
        end
    end

endmodule

/* rtl/core/bed_queue.sv */
module bed_queue
    import bed_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  entry_t                     push_data,
    output logic                       q_ready,
    input  logic                       pop,
    output logic                       q_valid,
    output entry_t                     head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slot_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign q_valid = (cnt_reg != '0);
    // a pop in the same cycle frees a slot
    assign q_ready = (cnt_reg != CW'(DEPTH)) || pop;
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;
    assign head    = slot_reg[rd_reg];
    assign count   = cnt_reg;

    always_comb
    begin
        wr_next  = (wr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_reg + 1'b1);
        rd_next  = (rd_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_reg + 1'b1);
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = CW'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_next;
            if (do_pop)
                rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/core/bed_back.sv */
module bed_back
    import bed_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  entry_t head,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output out_t   out_data
);

    logic sel_reg, sel_next;
    logic take;

    assign out_valid = q_valid;
    assign out_data  = sel_reg ? head.second : head.first;
    assign take      = out_valid && out_ready;
    // slot retires after its last result
    assign pop       = take && (!head.two || sel_reg);

    always_comb
    begin
        sel_next = sel_reg;
        if (take)
            sel_next = head.two && !sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

endmodule

/* rtl/core/backslash_escape_decoder_core.sv */
// Backslash escape decoder: takes one string byte per request (in_byte plus an
// end_of_text flag) and returns decoded character codes, one per output request.
// Plain bytes pass through, backslash escapes give control or literal characters,
// and backslash-# references (x + hex digits or decimal digits, optional ';')
// give a code saturated at 65535; zero or 0xfffe and above report status 5.
// A byte gives zero, one or two results; run_last marks the last of a byte's
// results and text_done marks every result of the final byte. The parser takes
// a byte every cycle; its results go into a QUEUE_DEPTH-slot queue and leave at
// one per cycle. A byte with two results (a reference closed by a non-';'
// terminator that itself yields a result) is always preceded by at least two
// bytes with none, so while the receiver takes every result the input runs at
// one byte per cycle with no stall; only a stalled receiver fills the queue and
// holds off input. When the queue is empty, the first result is offered in the
// cycle after the input is accepted. No start-up pass after reset.
`include "backslash_escape_decoder_core_assert.svh"

module backslash_escape_decoder_core
    import bed_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // front to queue
    logic        push;
    entry_t      push_data;
    logic        q_ready;
    front_stat_t stat;

    // queue to back
    logic          q_valid;
    entry_t        head;
    logic          pop;
    logic [CW-1:0] q_count;

    // parser: escape state and reference accumulator
    bed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_ready   (q_ready),
        .push      (push),
        .push_data (push_data),
        .stat      (stat)
    );

    // result slots between parser and output
    bed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head),
        .count     (q_count)
    );

    // output side: one result per accepted output request
    bed_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // the final byte always leaves the parser idle with a cleared accumulator
    `BED_ASSERT_NXT(a_end_clears, clk, rst_n, in_valid && in_ready && in_data.end_of_text, stat.mode_idle && stat.accum_zero)

    // queue fill never runs past its depth
    `BED_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, q_count <= CW'(QUEUE_DEPTH))

    // error results carry a zero code
    `BED_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.char_code == 16'd0)

endmodule
